// ----- design/bsil_pkg.sv -----
// ----------------------------------------------------------------------------
// bsil_pkg - shared types and constants for the bounded sorted insert list
// Sizes, operation and status codes, controller states, command/status structs.
// ----------------------------------------------------------------------------
package bsil_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam int OPCODE_W    = 2;
    localparam int KEY_W       = 32;
    localparam int READ_IDX_W  = 4;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int LIMIT_W     = 5;
    localparam int ENTRY_W     = 2 * KEY_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_READ_VALID = 3'd3,
        ST_READ_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // item taken this cycle
        logic scan_step;   // no hit, advance scan
        logic found;       // scan hit, settle position or drop
        logic shift_step;  // move one entry down
        logic write;       // place new pair
        logic emit;        // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_scan;     // incoming item is an insert with nonzero key
        logic scan_hit;    // insert position found
        logic drop;        // position not below the limit
        logic no_shift;    // nothing to move
        logic shift_last;  // this move is the last one
    } t_stat;

endpackage

// ----- design/bsil_if.sv -----
// ----------------------------------------------------------------------------
// bsil_if - valid/ready channels of the bounded sorted insert list
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface bsil_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsil_pkg::OPCODE_W-1:0]  opcode;
    logic [bsil_pkg::KEY_W-1:0]     new_start;
    logic [bsil_pkg::KEY_W-1:0]     new_end;
    logic [bsil_pkg::READ_IDX_W-1:0] read_index;

    modport source (output valid, opcode, new_start, new_end, read_index, input ready);
    modport sink   (input valid, opcode, new_start, new_end, read_index, output ready);
endinterface

interface bsil_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsil_pkg::STATUS_W-1:0]  status;
    logic [bsil_pkg::POS_W-1:0]     position;
    logic [bsil_pkg::COUNT_W-1:0]   entry_count;
    logic [bsil_pkg::KEY_W-1:0]     out_start;
    logic [bsil_pkg::KEY_W-1:0]     out_end;

    modport source (output valid, status, position, entry_count, out_start, out_end,
                    input ready);
    modport sink   (input valid, status, position, entry_count, out_start, out_end,
                    output ready);
endinterface

// ----- design/bounded_sorted_insert_list.sv -----
// ----------------------------------------------------------------------------
// bounded_sorted_insert_list - keeps the earliest (start, end) pairs in order
// Sorted list of up to MAX_ENTRIES pairs, ascending start, bounded by a limit.
// ----------------------------------------------------------------------------
//
//  port       dir  kind              what moves
//  i_in       in   valid/ready item  opcode, new_start, new_end, read_index
//  o_out      out  valid/ready item  status, position, entry_count, out_start/end
//  i_cfg_*    in   write strobe      list_limit (5 bits, reset 16)
//
//  Clear, read, no-op and zero-key insert: accept, then done. Insert: scan,
//  shift while entries move down, write, done; a dropped insert goes from
//  scan to done. s = entries scanned (position + 1, up to count + 1), m =
//  entries moved down; a placed item has s + m = deepest slot touched + 1,
//  at most 16. The entry RAM does one read and one write a cycle.
//  Reset (synchronous, i_rst_n low) empties the list; entry RAM is not cleared.
//  One item in flight; a finished result waits in the output register while
//  the next item is accepted and worked on.
//
module bounded_sorted_insert_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsil_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    bsil_in_if.sink                        i_in,
    bsil_out_if.source                     o_out
);
    bsil_pkg::t_cmd  cmd;
    bsil_pkg::t_stat stat;

    // controller: handshakes and the insert sequence
    bsil_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: entry RAM, count, limit and result register
    bsil_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_in.opcode),
        .i_new_start   (i_in.new_start),
        .i_new_end     (i_in.new_end),
        .i_read_index  (i_in.read_index),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_out.status),
        .o_position    (o_out.position),
        .o_entry_count (o_out.entry_count),
        .o_out_start   (o_out.out_start),
        .o_out_end     (o_out.out_end)
    );

endmodule

// ----- design/bsil_ram.sv -----
// ----------------------------------------------------------------------------
// bsil_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsil_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/bsil_dp.sv -----
// ----------------------------------------------------------------------------
// bsil_dp - datapath of the bounded sorted insert list
// Entry RAM, scan/shift index, count, limit register and result register.
// ----------------------------------------------------------------------------
module bsil_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsil_pkg::LIMIT_W-1:0]      i_cfg_wdata,
    input  logic [bsil_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [bsil_pkg::KEY_W-1:0]        i_new_start,
    input  logic [bsil_pkg::KEY_W-1:0]        i_new_end,
    input  logic [bsil_pkg::READ_IDX_W-1:0]   i_read_index,
    input  bsil_pkg::t_cmd                    i_cmd,
    output bsil_pkg::t_stat                   o_stat,
    output logic [bsil_pkg::STATUS_W-1:0]     o_status,
    output logic [bsil_pkg::POS_W-1:0]        o_position,
    output logic [bsil_pkg::COUNT_W-1:0]      o_entry_count,
    output logic [bsil_pkg::KEY_W-1:0]        o_out_start,
    output logic [bsil_pkg::KEY_W-1:0]        o_out_end
);
    localparam int CNT_W = bsil_pkg::CNT_W;
    localparam int IDX_W = bsil_pkg::IDX_W;
    localparam int KEY_W = bsil_pkg::KEY_W;

    // item and working registers
    logic [KEY_W-1:0]                    r_ns;
    logic [KEY_W-1:0]                    r_ne;
    logic [bsil_pkg::READ_IDX_W-1:0]     r_ri;
    logic [CNT_W-1:0]                    r_idx, n_idx;
    logic [bsil_pkg::POS_W-1:0]          r_pos;
    bsil_pkg::t_status                   r_status;
    logic [CNT_W-1:0]                    r_held;
    logic [bsil_pkg::LIMIT_W-1:0]        r_limit;

    // result register
    logic [bsil_pkg::STATUS_W-1:0]       r_o_status;
    logic [bsil_pkg::POS_W-1:0]          r_o_pos;
    logic [bsil_pkg::COUNT_W-1:0]        r_o_count;
    logic [KEY_W-1:0]                    r_o_start;
    logic [KEY_W-1:0]                    r_o_end;

    logic [CNT_W-1:0]                    lim_eff;
    logic [CNT_W-1:0]                    last;
    logic [CNT_W-1:0]                    pos_ext;
    logic                                ram_we;
    logic [IDX_W-1:0]                    ram_wr_addr;
    logic [bsil_pkg::ENTRY_W-1:0]        ram_wr_data;
    logic [IDX_W-1:0]                    ram_rd_addr;
    logic [bsil_pkg::ENTRY_W-1:0]        ram_rd_data;
    logic [KEY_W-1:0]                    rd_start;
    logic [KEY_W-1:0]                    rd_end;

    assign rd_start = ram_rd_data[bsil_pkg::ENTRY_W-1:KEY_W];
    assign rd_end   = ram_rd_data[KEY_W-1:0];

    assign lim_eff  = (int'(r_limit) > bsil_pkg::MAX_ENTRIES) ?
                      CNT_W'(bsil_pkg::MAX_ENTRIES) : CNT_W'(r_limit);
    // deepest slot touched: count grows, or the tail entry falls off
    assign last     = (r_held < lim_eff) ? r_held : (lim_eff - CNT_W'(1));
    assign pos_ext  = CNT_W'(r_pos);

    always_comb begin
        o_stat.in_scan    = (i_opcode == bsil_pkg::OP_INSERT) && (i_new_start != '0);
        o_stat.scan_hit   = (r_idx >= r_held) || (r_ns < rd_start);
        o_stat.drop       = (r_idx >= lim_eff);
        o_stat.no_shift   = (last == r_idx);
        o_stat.shift_last = (r_idx == pos_ext + CNT_W'(1));
    end

    // RAM read address: one entry ahead of the scan, two behind on shifts
    always_comb begin
        if (i_cmd.accept) begin
            ram_rd_addr = (i_opcode == bsil_pkg::OP_READ) ? IDX_W'(i_read_index) : '0;
        end else if (i_cmd.scan_step) begin
            ram_rd_addr = IDX_W'(r_idx + CNT_W'(1));
        end else if (i_cmd.found) begin
            ram_rd_addr = IDX_W'(last - CNT_W'(1));
        end else if (i_cmd.shift_step) begin
            ram_rd_addr = IDX_W'(r_idx - CNT_W'(2));
        end else begin
            ram_rd_addr = IDX_W'(r_ri);
        end
    end

    assign ram_we      = i_cmd.shift_step || i_cmd.write;
    assign ram_wr_addr = i_cmd.write ? IDX_W'(r_pos) : IDX_W'(r_idx);
    assign ram_wr_data = i_cmd.write ? {r_ns, r_ne} : ram_rd_data;

    bsil_ram #(
        .WIDTH (bsil_pkg::ENTRY_W),
        .DEPTH (bsil_pkg::MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.accept) begin
            n_idx = '0;
        end else if (i_cmd.scan_step) begin
            n_idx = r_idx + CNT_W'(1);
        end else if (i_cmd.found) begin
            n_idx = last;
        end else if (i_cmd.shift_step) begin
            n_idx = r_idx - CNT_W'(1);
        end
    end

    // control state: count and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_limit <= bsil_pkg::LIMIT_W'(16);
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.accept && (i_opcode == bsil_pkg::OP_CLEAR)) begin
                r_held <= '0;
            end else if (i_cmd.write && (r_held < lim_eff)) begin
                r_held <= r_held + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.accept) begin
            r_ns <= i_new_start;
            r_ne <= i_new_end;
            r_ri <= i_read_index;
            case (i_opcode)
                bsil_pkg::OP_INSERT: begin
                    r_status <= bsil_pkg::ST_IGNORED;
                    r_pos    <= '0;
                end
                bsil_pkg::OP_READ: begin
                    r_status <= (int'(i_read_index) < int'(r_held)) ?
                                bsil_pkg::ST_READ_VALID : bsil_pkg::ST_READ_EMPTY;
                    r_pos    <= bsil_pkg::POS_W'(i_read_index);
                end
                default: begin
                    r_status <= bsil_pkg::ST_READ_EMPTY;
                    r_pos    <= '0;
                end
            endcase
        end else if (i_cmd.found) begin
            if (o_stat.drop) begin
                r_status <= bsil_pkg::ST_DROPPED;
                r_pos    <= '0;
            end else begin
                r_pos    <= bsil_pkg::POS_W'(r_idx);
            end
        end else if (i_cmd.write) begin
            r_status <= bsil_pkg::ST_INSERTED;
        end

        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_pos    <= r_pos;
            r_o_count  <= bsil_pkg::COUNT_W'(r_held);
            r_o_start  <= (r_status == bsil_pkg::ST_READ_VALID) ? rd_start : '0;
            r_o_end    <= (r_status == bsil_pkg::ST_READ_VALID) ? rd_end : '0;
        end
    end

    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_count;
    assign o_out_start   = r_o_start;
    assign o_out_end     = r_o_end;

endmodule

// ----- design/bsil_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsil_ctrl - controller of the bounded sorted insert list
// Sequences scan, shift and write for inserts; owns both handshakes.
// ----------------------------------------------------------------------------
module bsil_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bsil_pkg::t_stat  i_stat,
    output bsil_pkg::t_cmd   o_cmd
);
    bsil_pkg::t_state r_state, n_state;
    logic             r_out_valid;
    logic             out_free;
    logic             accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = (r_state == bsil_pkg::S_IDLE) && i_in_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsil_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_scan ? bsil_pkg::S_SCAN : bsil_pkg::S_DONE;
                end
            end
            bsil_pkg::S_SCAN: begin
                if (i_stat.scan_hit) begin
                    if (i_stat.drop) begin
                        n_state = bsil_pkg::S_DONE;
                    end else if (i_stat.no_shift) begin
                        n_state = bsil_pkg::S_WRITE;
                    end else begin
                        n_state = bsil_pkg::S_SHIFT;
                    end
                end
            end
            bsil_pkg::S_SHIFT: begin
                if (i_stat.shift_last) begin
                    n_state = bsil_pkg::S_WRITE;
                end
            end
            bsil_pkg::S_WRITE: begin
                n_state = bsil_pkg::S_DONE;
            end
            bsil_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bsil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsil_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.scan_step  = (r_state == bsil_pkg::S_SCAN) && !i_stat.scan_hit;
        o_cmd.found      = (r_state == bsil_pkg::S_SCAN) && i_stat.scan_hit;
        o_cmd.shift_step = (r_state == bsil_pkg::S_SHIFT);
        o_cmd.write      = (r_state == bsil_pkg::S_WRITE);
        o_cmd.emit       = (r_state == bsil_pkg::S_DONE) && out_free;
    end

    assign o_in_ready  = (r_state == bsil_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsil_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == bsil_pkg::S_SCAN || r_state == bsil_pkg::S_DONE))
        else $error("accepted item went to an unexpected state");

    a_shift_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsil_pkg::S_SHIFT |=>
            (r_state == bsil_pkg::S_SHIFT || r_state == bsil_pkg::S_WRITE))
        else $error("shift left without placing the new pair");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsil_pkg::S_WRITE |=> r_state == bsil_pkg::S_DONE)
        else $error("write state held for more than one cycle");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsil_pkg::S_DONE && r_out_valid && !i_out_ready) |=>
            (r_state == bsil_pkg::S_DONE && r_out_valid))
        else $error("result lost while output stalled");

endmodule
